>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the chunked body decoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk, off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold at a rising edge of clk
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/hcbd_pkg.sv
// ---------------------------------------------------------------------------
// hcbd_pkg
// types and constants of the http chunked body decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int MAX_CHUNK_BYTES = 65536;
  localparam int SIZE_LINE_BYTES = 20;

  localparam int SIZE_W     = 17;
  localparam int LINE_CNT_W = 5;
  localparam int LEN_W      = 16;
  localparam int NUM_W      = 32;

  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // prefix tracking
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_ZERO = 2'd1;
  localparam logic [1:0] PFX_DONE = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0a;

  typedef enum logic [4:0] {
    PH_LINE   = 5'b00001,
    PH_DATA   = 5'b00010,
    PH_TRAIL  = 5'b00100,
    PH_ENDED  = 5'b01000,
    PH_FAILED = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]        prefix_step;
    logic              digit_seen;
    logic              parse_stopped;
    logic [SIZE_W-1:0] size_value;
    logic              size_overflow;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    prefix_step:   PFX_NONE,
    digit_seen:    1'b0,
    parse_stopped: 1'b0,
    size_value:    '0,
    size_overflow: 1'b0
  };

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic [NUM_W-1:0] number;
  } result_t;

endpackage

>>> sv/hcbd_size_scan.sv
// ---------------------------------------------------------------------------
// hcbd_size_scan
// one step of the hex scan of a chunk size line
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_size_scan (
  input  hcbd_pkg::scan_state_t cur,
  input  logic [7:0]            byte_in,
  output hcbd_pkg::scan_state_t nxt
);
  import hcbd_pkg::*;

  logic       is_blank;
  logic       is_x;
  logic       hex_ok;
  logic [3:0] digit;

  always_comb begin
    is_blank = (byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0b) ||
               (byte_in == 8'h0c) || (byte_in == 8'h0d);
    is_x     = (byte_in == 8'h78) || (byte_in == 8'h58);
    hex_ok   = 1'b1;
    digit    = 4'd0;
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      digit = 4'(byte_in - 8'h30);
    end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
      digit = 4'(byte_in - 8'h57);
    end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
      digit = 4'(byte_in - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    nxt = cur;
    if (!cur.parse_stopped) begin
      if (!cur.digit_seen && is_blank) begin
        nxt = cur;
      end else if (cur.prefix_step == PFX_ZERO && is_x) begin
        nxt.prefix_step = PFX_DONE;
      end else if (!hex_ok) begin
        nxt.parse_stopped = 1'b1;
      end else begin
        nxt.prefix_step = (!cur.digit_seen && digit == 4'd0) ? PFX_ZERO : PFX_DONE;
        nxt.digit_seen  = 1'b1;
        if (!cur.size_overflow) begin
          // shifting in a digit overflows once any of the top four bits is set
          if (cur.size_value[SIZE_W-1 -: 4] != 4'd0) begin
            nxt.size_value    = SIZE_SAT;
            nxt.size_overflow = 1'b1;
          end else begin
            nxt.size_value = {cur.size_value[SIZE_W-5:0], digit};
          end
        end
      end
    end
  end

endmodule

>>> sv/hcbd_result_reg.sv
// ---------------------------------------------------------------------------
// hcbd_result_reg
// output register holding one result beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hcbd_pkg::result_t d,
  output logic              space,
  output logic              full,
  output hcbd_pkg::result_t q,
  input  logic              take
);
  import hcbd_pkg::*;

  logic full_next;

  assign space = !full || take;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

>>> sv/http_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// decoder for an http chunked transfer body, one byte per beat
// ---------------------------------------------------------------------------
// Takes one body byte per beat and sustains one byte per clock cycle while the
// output side keeps taking results. A byte sits in the input register, is
// decoded in a single pass against the chunk state and lands in the output
// register; the state update is what sets the rate. Each size line (at most
// 20 bytes, ended by newline) is scanned as hex with leading blanks skipped
// and an optional 0x prefix. A zero size reports stream end ok, a size too
// big, an overflow, a line with no digit or a line too long reports an error.
// Payload bytes come out as kind 0, the two trailer bytes are dropped and a
// chunk done beat carries the length and the running chunk number. After end
// or error every byte is consumed silently until reset.
`timescale 1ns / 1ps

module http_chunked_body_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_byte,
  output logic [hcbd_pkg::LEN_W-1:0]   chunk_length,
  output logic [hcbd_pkg::NUM_W-1:0]   chunk_number
);
  import hcbd_pkg::*;

  `include "assert_macros.svh"

  // input register
  logic       in_full;
  logic       in_full_next;
  logic [7:0] in_data;

  // chunk state
  phase_t                phase;
  phase_t                phase_next;
  logic [LINE_CNT_W-1:0] line_count;
  logic [LINE_CNT_W-1:0] line_count_next;
  scan_state_t           scan;
  scan_state_t           scan_next;
  scan_state_t           scan_step;
  logic [SIZE_W-1:0]     bytes_left;
  logic [SIZE_W-1:0]     bytes_left_next;
  logic [1:0]            trailer_left;
  logic [1:0]            trailer_left_next;
  logic [NUM_W-1:0]      chunks_done;
  logic [NUM_W-1:0]      chunks_done_next;

  // result path
  logic    res_load;
  result_t res_d;
  result_t res_q;
  logic    res_space;
  logic    fire;
  logic    too_big;

  // decode step runs when a byte is held and the output register has room
  assign fire     = in_full && res_space;
  assign in_ready = !in_full || fire;

  always_comb begin
    in_full_next = in_full;
    if (in_valid && in_ready) begin
      in_full_next = 1'b1;
    end else if (fire) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= in_byte;
    end
  end

  hcbd_size_scan u_scan (
    .cur     (scan),
    .byte_in (in_data),
    .nxt     (scan_step)
  );

  // size plus the two trailer bytes must fit the chunk limit
  assign too_big = ({1'b0, scan.size_value} + (SIZE_W+1)'(2)) >
                   (SIZE_W+1)'(MAX_CHUNK_BYTES);

  always_comb begin
    phase_next        = phase;
    line_count_next   = line_count;
    scan_next         = scan;
    bytes_left_next   = bytes_left;
    trailer_left_next = trailer_left;
    chunks_done_next  = chunks_done;
    res_load          = 1'b0;
    res_d.kind        = KIND_BYTE;
    res_d.data        = 8'd0;
    res_d.length      = '0;
    res_d.number      = chunks_done;

    if (fire) begin
      case (phase)
        PH_LINE: begin
          if (in_data == CHAR_NL) begin
            if (!scan.digit_seen) begin
              phase_next = PH_FAILED;
              res_load   = 1'b1;
              res_d.kind = KIND_ERR;
            end else if (scan.size_value == '0) begin
              phase_next = PH_ENDED;
              res_load   = 1'b1;
              res_d.kind = KIND_END;
            end else if (scan.size_overflow || too_big) begin
              phase_next = PH_FAILED;
              res_load   = 1'b1;
              res_d.kind = KIND_ERR;
            end else begin
              bytes_left_next = scan.size_value;
              phase_next      = PH_DATA;
            end
          end else begin
            scan_next       = scan_step;
            line_count_next = line_count + LINE_CNT_W'(1);
            // line too long: this byte filled the line without a newline
            if (line_count_next >= LINE_CNT_W'(SIZE_LINE_BYTES)) begin
              phase_next = PH_FAILED;
              res_load   = 1'b1;
              res_d.kind = KIND_ERR;
            end
          end
        end
        PH_DATA: begin
          bytes_left_next = bytes_left - SIZE_W'(1);
          if (bytes_left_next == '0) begin
            phase_next        = PH_TRAIL;
            trailer_left_next = 2'd2;
          end
          res_load   = 1'b1;
          res_d.kind = KIND_BYTE;
          res_d.data = in_data;
        end
        PH_TRAIL: begin
          trailer_left_next = trailer_left - 2'd1;
          if (trailer_left_next == 2'd0) begin
            chunks_done_next = chunks_done + NUM_W'(1);
            scan_next        = SCAN_CLEAR;
            line_count_next  = '0;
            phase_next       = PH_LINE;
            res_load         = 1'b1;
            res_d.kind       = KIND_DONE;
            res_d.length     = scan.size_value[LEN_W-1:0];
            res_d.number     = chunks_done_next;
          end
        end
        default: begin
          // ended or failed: bytes are swallowed
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE;
      line_count   <= '0;
      scan         <= SCAN_CLEAR;
      bytes_left   <= '0;
      trailer_left <= 2'd0;
      chunks_done  <= '0;
    end else begin
      phase        <= phase_next;
      line_count   <= line_count_next;
      scan         <= scan_next;
      bytes_left   <= bytes_left_next;
      trailer_left <= trailer_left_next;
      chunks_done  <= chunks_done_next;
    end
  end

  hcbd_result_reg u_result (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .d     (res_d),
    .space (res_space),
    .full  (out_valid),
    .q     (res_q),
    .take  (out_ready)
  );

  assign out_kind     = res_q.kind;
  assign out_byte     = res_q.data;
  assign chunk_length = res_q.length;
  assign chunk_number = res_q.number;

  // end and error are terminal
  `ASSERT_CLK(a_end_sticky, (phase == PH_ENDED) |=> (phase == PH_ENDED), "ended phase left")
  `ASSERT_CLK(a_fail_sticky, (phase == PH_FAILED) |=> (phase == PH_FAILED), "failed phase left")
  // every payload byte yields a beat
  `ASSERT_CLK(a_data_emits, (fire && phase == PH_DATA) |-> res_load, "payload byte dropped")
  `ASSERT_NEVER(a_data_nonzero, (phase == PH_DATA) && (bytes_left == '0), "empty chunk in data")
  `ASSERT_NEVER(a_line_bound, (phase == PH_LINE) &&
                (line_count >= LINE_CNT_W'(SIZE_LINE_BYTES)), "size line count past limit")

endmodule

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the http chunked body decoder
// ---------------------------------------------------------------------------
// Streams one chunked body into the decoder, one byte per input beat. A
// short table of hand-written chunks comes first: size line forms, payload
// extremes and the longest legal size line. Random well-formed chunks follow
// under four idling mixes. A single terminating line, picked at random,
// closes the stream, and a tail of noise then checks that the block stays
// silent. A local decoder model predicts every output beat. Each output
// beat is checked field by field against the oldest prediction.
`timescale 1ns / 1ps

module tb;
  import hcbd_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 300;   // long output back-pressure stretch
  localparam int PHASE_BYTES  = 220;   // random bytes per idling mix
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_byte;
  logic [LEN_W-1:0]    chunk_length;
  logic [NUM_W-1:0]    chunk_number;

  http_chunked_body_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .chunk_length (chunk_length),
    .chunk_number (chunk_number)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one hand-written chunk: size line, payload pattern, two trailer bytes,
  // and optionally the chunk done beat it must end with
  typedef struct {
    string       line;
    int unsigned count;
    logic [7:0]  base;
    logic [7:0]  stride;
    logic [15:0] trailer;
    bit          typed;
    logic [15:0] exp_len;
    logic [31:0] exp_num;
  } chunk_row_t;

  chunk_row_t  directed_rows[$];
  result_t     pending_results[$];

  // idling knobs, percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_output    = 1'b0;

  int unsigned bytes_offered = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;

  // model state of the decoder
  phase_t            stream_phase;
  logic [4:0]        line_cnt;
  logic [1:0]        pfx_step;
  bit                got_digit;
  bit                scan_done;
  logic [SIZE_W-1:0] size_acc;
  bit                size_sat;
  logic [SIZE_W-1:0] payload_left;
  logic [1:0]        trail_left;
  logic [NUM_W-1:0]  chunks_seen;

  // ---------------------------------------------------------------------
  // decoder model: advance the state by one byte, report the beat it makes
  // ---------------------------------------------------------------------
  task automatic decode_byte(input logic [7:0] c, output bit produced,
                             output result_t res);
    bit          blank;
    int unsigned d;
    int unsigned acc;
    produced = 1'b0;
    res      = '0;
    res.number = chunks_seen;
    case (stream_phase)
      PH_LINE: begin
        if (c == CHAR_NL) begin
          produced = 1'b1;
          if (!got_digit) begin
            stream_phase = PH_FAILED;
            res.kind = KIND_ERR;
          end else if (size_acc == '0) begin
            stream_phase = PH_ENDED;
            res.kind = KIND_END;
          end else if (size_sat || int'(size_acc) + 2 > MAX_CHUNK_BYTES) begin
            stream_phase = PH_FAILED;
            res.kind = KIND_ERR;
          end else begin
            // good size: payload follows, nothing to report yet
            produced = 1'b0;
            payload_left = size_acc;
            stream_phase = PH_DATA;
          end
        end else begin
          // hex scan of one size line byte
          blank = (c == " " || c == "\011" || c == "\013" ||
                   c == "\014" || c == "\015");
          if (scan_done || (!got_digit && blank)) begin
            // skipped
          end else if (pfx_step == PFX_ZERO && (c == "x" || c == "X")) begin
            pfx_step = PFX_DONE;
          end else begin
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else d = 16;
            if (d >= 16) begin
              scan_done = 1'b1;
            end else begin
              pfx_step  = (!got_digit && d == 0) ? PFX_ZERO : PFX_DONE;
              got_digit = 1'b1;
              if (!size_sat) begin
                acc = {15'd0, size_acc} * 16 + d;
                if (acc > SIZE_SAT) begin
                  size_acc = SIZE_SAT;
                  size_sat = 1'b1;
                end else begin
                  size_acc = acc[SIZE_W-1:0];
                end
              end
            end
          end
          line_cnt = line_cnt + 5'd1;
          if (line_cnt >= SIZE_LINE_BYTES) begin
            // line too long
            stream_phase = PH_FAILED;
            produced = 1'b1;
            res.kind = KIND_ERR;
          end
        end
      end
      PH_DATA: begin
        if (payload_left != '0) payload_left = payload_left - 1'b1;
        if (payload_left == '0) begin
          stream_phase = PH_TRAIL;
          trail_left = 2'd2;
        end
        produced = 1'b1;
        res.kind = KIND_BYTE;
        res.data = c;
      end
      PH_TRAIL: begin
        if (trail_left != 2'd0) trail_left = trail_left - 2'd1;
        if (trail_left == 2'd0) begin
          // trailer bytes are dropped without a look
          chunks_seen = chunks_seen + 1'b1;
          produced = 1'b1;
          res.kind = KIND_DONE;
          res.length = size_acc[LEN_W-1:0];
          res.number = chunks_seen;
          stream_phase = PH_LINE;
          line_cnt  = '0;
          pfx_step  = PFX_NONE;
          got_digit = 1'b0;
          scan_done = 1'b0;
          size_acc  = '0;
          size_sat  = 1'b0;
        end
      end
      default: begin
        // ended or failed: every byte is swallowed
      end
    endcase
  endtask

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // ---------------------------------------------------------------------
  // input side: offer one byte, wait for its beat, record the prediction
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit use_given = 1'b0,
                           input result_t given = '0);
    bit      produced;
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_offered++;
    decode_byte(b, produced, res);
    if (produced) pending_results.push_back(use_given ? given : res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic add_row(input string line, input int unsigned count,
                         input logic [7:0] base, input logic [7:0] stride,
                         input logic [15:0] trailer, input bit typed = 1'b0,
                         input logic [15:0] exp_len = '0,
                         input logic [31:0] exp_num = '0);
    chunk_row_t r;
    r.line = line;
    r.count = count;
    r.base = base;
    r.stride = stride;
    r.trailer = trailer;
    r.typed = typed;
    r.exp_len = exp_len;
    r.exp_num = exp_num;
    directed_rows.push_back(r);
  endtask

  // one random well-formed chunk: blanks, optional prefix, leading zeros,
  // hex size in either case, stray bytes after the stop, random payload
  task automatic send_random_chunk();
    logic [7:0]  line_q[$];
    string       digits;
    int unsigned size;
    int unsigned tail;
    if ($urandom_range(15) == 0) size = $urandom_range(41, 600);
    else size = $urandom_range(1, 40);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(4))
        0: line_q.push_back(" ");
        1: line_q.push_back("\011");
        2: line_q.push_back("\013");
        3: line_q.push_back("\014");
        default: line_q.push_back("\015");
      endcase
    end
    if ($urandom_range(3) == 0) begin
      line_q.push_back("0");
      line_q.push_back($urandom_range(1) ? "x" : "X");
    end
    repeat ($urandom_range(0, 3)) line_q.push_back("0");
    digits = $sformatf("%0x", size);
    if ($urandom_range(1)) digits = digits.toupper();
    for (int i = 0; i < digits.len(); i++) line_q.push_back(digits[i]);
    // stop byte, then anything but a newline up to the line limit
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(4))
        0: line_q.push_back(";");
        1: line_q.push_back(" ");
        2: line_q.push_back("\015");
        3: line_q.push_back("g");
        default: line_q.push_back("x");
      endcase
      tail = $urandom_range(0, SIZE_LINE_BYTES - 1 - line_q.size());
      repeat (tail) begin
        logic [7:0] t;
        t = 8'($urandom_range(255));
        line_q.push_back(t == CHAR_NL ? 8'h00 : t);
      end
    end
    foreach (line_q[i]) send_byte(line_q[i]);
    send_byte(CHAR_NL);
    repeat (size) send_byte(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) begin
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte("\015");
      send_byte(CHAR_NL);
    end
  endtask

  task automatic run_random_phase(input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_offered;
    while (bytes_offered - start < PHASE_BYTES) send_random_chunk();
  endtask

  // the one line that closes the stream, either ok or with an error
  task automatic send_closing_line();
    case ($urandom_range(7))
      0: send_text("0\015\n");
      1: send_text("  0000;last\n");
      2: send_text("0x\n");                         // bare prefix reads as zero
      3: send_text("\n");                           // no digit at all
      4: send_text("\011 zz\n");                    // no digit, stop byte first
      5: send_text($urandom_range(1) ? "-5\n" : "+5\n");  // sign stops the scan
      6: begin
        // line too long: the twentieth byte without a newline fails
        repeat (SIZE_LINE_BYTES) begin
          logic [7:0] t;
          t = 8'($urandom_range(255));
          send_byte(t == CHAR_NL ? "1" : t);
        end
      end
      default: begin
        case ($urandom_range(3))
          0: send_text("FFFF\n");                  // size plus trailer too big
          1: send_text("10000\n");
          2: send_text("1ffff\n");
          default: send_text("fffffff\n");         // accumulator saturates
        endcase
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // output side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_output) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_output = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // check every output beat against the oldest prediction
  always @(posedge clk) begin : check_beats
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected beat kind=%0d byte=%02h len=%0d num=%0d",
                               out_kind, out_byte, chunk_length, chunk_number));
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data ||
            chunk_length !== want.length || chunk_number !== want.number) begin
          note_failure($sformatf(
            "expected kind=%0d byte=%02h len=%0d num=%0d, got kind=%0d byte=%02h len=%0d num=%0d",
            want.kind, want.data, want.length, want.number,
            out_kind, out_byte, chunk_length, chunk_number));
        end
      end
    end
  end

  // watchdog: too long without any beat means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    stream_phase = PH_LINE;
    line_cnt     = '0;
    pfx_step     = PFX_NONE;
    got_digit    = 1'b0;
    scan_done    = 1'b0;
    size_acc     = '0;
    size_sat     = 1'b0;
    payload_left = '0;
    trail_left   = 2'd0;
    chunks_seen  = '0;

    // size line, count, payload base and stride, trailer, chunk done beat
    add_row("1\n", 1, 8'h00, 8'h00, 16'h0d0a, 1'b1, 16'd1, 32'd1);
    add_row("ff\n", 255, 8'h00, 8'h01, 16'h0d0a, 1'b1, 16'd255, 32'd2);
    add_row(" \011\013\014\0150x1A\n", 26, 8'hff, 8'h00, 16'h0d0a);
    add_row("0X0010;ext=1\015\n", 16, 8'h80, 8'h03, 16'h7879);
    add_row("00000000000000000a\n", 10, 8'h55, 8'h11, 16'h0d0a);
    add_row("   0000000000000003\n", 3, 8'haa, 8'h01, 16'h0d0a);  // longest legal line
    add_row("40\n", 64, 8'h01, 8'h01, 16'h0d0a, 1'b1, 16'd64, 32'd7);
    add_row("2 junk\n", 2, 8'h7f, 8'h01, 16'h0d0a);
    add_row("0x05 \n", 5, 8'h0a, 8'h00, 16'hffff);
    add_row("1g\n", 1, 8'h30, 8'h00, 16'h0a0d);
    add_row("\015\0151\015\n", 1, 8'h0a, 8'h00, 16'h0a0a);
    add_row("3\n", 3, 8'h00, 8'h00, 16'h0000);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (directed_rows[i]) begin
      send_text(directed_rows[i].line);
      for (int k = 0; k < directed_rows[i].count; k++)
        send_byte(8'(directed_rows[i].base + k * directed_rows[i].stride));
      send_byte(directed_rows[i].trailer[15:8]);
      send_byte(directed_rows[i].trailer[7:0], directed_rows[i].typed,
                '{kind: KIND_DONE, data: 8'h00, length: directed_rows[i].exp_len,
                  number: directed_rows[i].exp_num});
    end

    // full-rate input while the output holds off, so the block backs up
    hold_output = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(75, 0);
    run_random_phase(0, 75);
    run_random_phase(23, 23);

    // close the stream, then noise that must produce nothing
    send_closing_line();
    repeat (40) send_byte(8'($urandom_range(255)));
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
